// ===== rtl/msm_pkg.sv =====
package msm_pkg;

  localparam int TRACKS         = 4;
  localparam int FRAME_TRACKS   = 4;
  localparam int GAIN_FRAC_BITS = 14;
  localparam int SAMPLE_W       = 16;
  localparam int NARROW_W       = 8;
  localparam int GAIN_W         = 16;
  localparam int CFG_W          = 64;
  localparam int CFG_IDX_W      = 2;
  localparam int PROD_W         = SAMPLE_W + GAIN_W - GAIN_FRAC_BITS;
  localparam int SUM_W          = PROD_W + 1 + $clog2(TRACKS);

  localparam logic signed [SUM_W-1:0] MAX_WIDE   = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] MIN_WIDE   = -SUM_W'(32768);
  localparam logic signed [SUM_W-1:0] MAX_NARROW = SUM_W'(127);
  localparam logic signed [SUM_W-1:0] MIN_NARROW = -SUM_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_GAINS     = 2'd0,
    CFG_RIGHT_GAINS    = 2'd1,
    CFG_STEREO_TRACKS  = 2'd2,
    CFG_NARROW_SAMPLES = 2'd3
  } cfg_reg_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [PROD_W-1:0]          prod_t;

  typedef struct packed {
    sample_t                 left_in_0;
    sample_t                 right_in_0;
    sample_t                 left_in_1;
    sample_t                 right_in_1;
    sample_t                 left_in_2;
    sample_t                 right_in_2;
    sample_t                 left_in_3;
    sample_t                 right_in_3;
    logic [FRAME_TRACKS-1:0] present_mask;
  } frame_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } mix_t;

endpackage

// ===== rtl/msm_frame_if.sv =====
interface msm_frame_if;
  import msm_pkg::*;

  logic   valid;
  logic   ready;
  frame_t frame;

  modport source (output valid, output frame, input ready);
  modport sink (input valid, input frame, output ready);
endinterface

// ===== rtl/msm_mix_if.sv =====
interface msm_mix_if;
  import msm_pkg::*;

  logic valid;
  logic ready;
  mix_t mix;

  modport source (output valid, output mix, input ready);
  modport sink (input valid, input mix, output ready);
endinterface

// ===== rtl/multitrack_stereo_mixer.sv =====
// Four-track stereo mixer with saturation. Each beat on frame_i carries a left and a right
// sample per track plus a mask of the tracks present; each beat on mix_o carries the mixed,
// saturated left and right samples. Mono tracks feed their left sample to both mixes, gains
// are unsigned Q2.14 and each product truncates toward zero. One frame per clock is taken
// while mix_o is not stalled; the input, multiplier and adder/clip output registers form
// the pipeline, and each stage advances independently so bubbles are squeezed out when mix_o
// stalls. Configuration writes on cfg_* take effect at once and are meant for idle periods.
module multitrack_stereo_mixer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [msm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [msm_pkg::CFG_W-1:0]     cfg_wdata_i,
  msm_frame_if.sink                     frame_i,
  msm_mix_if.source                     mix_o
);
  import msm_pkg::*;

  function automatic sample_t clip(input logic signed [SUM_W-1:0] v, input logic narrow);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W-1:0] r;
    hi = narrow ? MAX_NARROW : MAX_WIDE;
    lo = narrow ? MIN_NARROW : MIN_WIDE;
    r  = v;
    if (v > hi) r = hi;
    if (v < lo) r = lo;
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic sample_t widen(input sample_t raw, input logic narrow);
    sample_t s;
    s = narrow ? {{(SAMPLE_W-NARROW_W){raw[NARROW_W-1]}}, raw[NARROW_W-1:0]} : raw;
    return s;
  endfunction

  // configuration
  logic [CFG_W-1:0]        left_gains_q;
  logic [CFG_W-1:0]        right_gains_q;
  logic [FRAME_TRACKS-1:0] stereo_q;
  logic                    narrow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_gains_q  <= '0;
      right_gains_q <= '0;
      stereo_q      <= '0;
      narrow_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_LEFT_GAINS:     left_gains_q  <= cfg_wdata_i;
        CFG_RIGHT_GAINS:    right_gains_q <= cfg_wdata_i;
        CFG_STEREO_TRACKS:  stereo_q      <= cfg_wdata_i[FRAME_TRACKS-1:0];
        CFG_NARROW_SAMPLES: narrow_q      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // stage handshakes
  logic s1_vld_q, s2_vld_q, s3_vld_q;
  logic s1_rdy, s2_rdy, s3_rdy;

  assign s3_rdy        = !s3_vld_q || mix_o.ready;
  assign s2_rdy        = !s2_vld_q || s3_rdy;
  assign s1_rdy        = !s1_vld_q || s2_rdy;
  assign frame_i.ready = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_q <= frame_i.valid;
      if (s2_rdy) s2_vld_q <= s1_vld_q;
      if (s3_rdy) s3_vld_q <= s2_vld_q;
    end
  end

  // stage 1: input register
  frame_t s1_frame_q;

  always_ff @(posedge clk_i) begin
    if (s1_rdy && frame_i.valid) s1_frame_q <= frame_i.frame;
  end

  // stage 1 -> 2: sample select and magnitude products
  sample_t                 l_raw [FRAME_TRACKS];
  sample_t                 r_raw [FRAME_TRACKS];
  sample_t                 l_smp [TRACKS];
  sample_t                 r_smp [TRACKS];
  logic [SAMPLE_W-1:0]     l_mag [TRACKS];
  logic [SAMPLE_W-1:0]     r_mag [TRACKS];
  logic [2*SAMPLE_W-1:0]   l_full [TRACKS];
  logic [2*SAMPLE_W-1:0]   r_full [TRACKS];
  prod_t                   lp_d [TRACKS];
  prod_t                   rp_d [TRACKS];
  logic [TRACKS-1:0]       lneg_d, rneg_d;
  prod_t                   lp_q [TRACKS];
  prod_t                   rp_q [TRACKS];
  logic [TRACKS-1:0]       lneg_q, rneg_q;

  assign l_raw[0] = s1_frame_q.left_in_0;
  assign r_raw[0] = s1_frame_q.right_in_0;
  assign l_raw[1] = s1_frame_q.left_in_1;
  assign r_raw[1] = s1_frame_q.right_in_1;
  assign l_raw[2] = s1_frame_q.left_in_2;
  assign r_raw[2] = s1_frame_q.right_in_2;
  assign l_raw[3] = s1_frame_q.left_in_3;
  assign r_raw[3] = s1_frame_q.right_in_3;

  always_comb begin
    for (int k = 0; k < TRACKS; k++) begin
      l_smp[k]  = widen(l_raw[k], narrow_q);
      r_smp[k]  = stereo_q[k] ? widen(r_raw[k], narrow_q) : l_smp[k];
      l_mag[k]  = l_smp[k][SAMPLE_W-1] ? SAMPLE_W'(-l_smp[k]) : SAMPLE_W'(l_smp[k]);
      r_mag[k]  = r_smp[k][SAMPLE_W-1] ? SAMPLE_W'(-r_smp[k]) : SAMPLE_W'(r_smp[k]);
      l_full[k] = (2*SAMPLE_W)'(l_mag[k]) * (2*SAMPLE_W)'(left_gains_q[GAIN_W*k +: GAIN_W]);
      r_full[k] = (2*SAMPLE_W)'(r_mag[k]) * (2*SAMPLE_W)'(right_gains_q[GAIN_W*k +: GAIN_W]);
      // absent tracks contribute nothing
      lp_d[k]   = s1_frame_q.present_mask[k] ?
                  l_full[k][GAIN_FRAC_BITS +: PROD_W] : '0;
      rp_d[k]   = s1_frame_q.present_mask[k] ?
                  r_full[k][GAIN_FRAC_BITS +: PROD_W] : '0;
      lneg_d[k] = l_smp[k][SAMPLE_W-1];
      rneg_d[k] = r_smp[k][SAMPLE_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_vld_q) begin
      lp_q   <= lp_d;
      rp_q   <= rp_d;
      lneg_q <= lneg_d;
      rneg_q <= rneg_d;
    end
  end

  // stage 2 -> 3: signed sum and saturation
  logic signed [SUM_W-1:0] l_term [TRACKS];
  logic signed [SUM_W-1:0] r_term [TRACKS];
  logic signed [SUM_W-1:0] l_sum, r_sum;
  mix_t                    mix_d;
  mix_t                    s3_mix_q;

  always_comb begin
    l_sum = '0;
    r_sum = '0;
    for (int k = 0; k < TRACKS; k++) begin
      l_term[k] = lneg_q[k] ? -SUM_W'(lp_q[k]) : SUM_W'(lp_q[k]);
      r_term[k] = rneg_q[k] ? -SUM_W'(rp_q[k]) : SUM_W'(rp_q[k]);
      l_sum     = l_sum + l_term[k];
      r_sum     = r_sum + r_term[k];
    end
    mix_d.left_out  = clip(l_sum, narrow_q);
    mix_d.right_out = clip(r_sum, narrow_q);
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_vld_q) s3_mix_q <= mix_d;
  end

  assign mix_o.valid = s3_vld_q;
  assign mix_o.mix   = s3_mix_q;

  // narrow mode keeps the mix within the 8-bit range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_vld_q && narrow_q && $stable(narrow_q) && $past(narrow_q) && $past(narrow_q, 2)
      && $past(s2_vld_q && s3_rdy))
    |-> (SUM_W'(s3_mix_q.left_out) <= MAX_NARROW && SUM_W'(s3_mix_q.left_out) >= MIN_NARROW
      && SUM_W'(s3_mix_q.right_out) <= MAX_NARROW && SUM_W'(s3_mix_q.right_out) >= MIN_NARROW))
    else $error("narrow mix out of range");

  // an empty output register never holds the input back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s3_vld_q |-> frame_i.ready)
    else $error("input stalled with empty output stage");

  // a frame in stage 1 moves on whenever stage 2 can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s2_rdy) |=> s2_vld_q)
    else $error("frame lost between stages 1 and 2");

  // a frame in stage 2 moves on whenever the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && s3_rdy) |=> s3_vld_q)
    else $error("frame lost between stages 2 and 3");

endmodule
